### design/ldpc_frame_parameter_calc_unit_defines.svh
// ----------------------------------------------------------------------------
// ldpc frame parameter calculator assertion macros
// shared property forms used by the top level checks
// ----------------------------------------------------------------------------
`ifndef LDPC_FRAME_PARAMETER_CALC_UNIT_DEFINES_SVH
`define LDPC_FRAME_PARAMETER_CALC_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define LFP_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define LFP_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### design/ldpcfp_pkg.sv
// ----------------------------------------------------------------------------
// ldpcfp_pkg
// widths, types and rate tables of the ldpc frame parameter calculator
// ----------------------------------------------------------------------------
package ldpcfp_pkg;

	localparam int PAYLOAD_WIDTH = 20;
	localparam int RATE_W        = 2;
	localparam int BITS_W        = 4;
	localparam int CARR_W        = 12;
	localparam int CFG_W         = 12;
	localparam int BPS_W         = BITS_W + CARR_W;
	localparam int DVD_W         = PAYLOAD_WIDTH + 3;
	localparam int DIVA_W        = 19;
	localparam int DIVB_W        = 14;
	localparam int SYM_W         = DVD_W + 1;
	localparam int TCB_W         = DVD_W + 2;
	localparam int SHARE_W       = 10;
	localparam int PROD_W        = SYM_W + SHARE_W;
	localparam int EXT_W         = PROD_W + 4;

	localparam logic [10:0] CW_SHORT     = 11'd648;
	localparam logic [10:0] CW_MID       = 11'd1296;
	localparam logic [10:0] CW_LONG      = 11'd1944;
	localparam logic [11:0] TWO_CW_LIMIT = 12'd2592;
	localparam logic [11:0] MARGIN_SHORT = 12'd912;
	localparam logic [11:0] MARGIN_MID   = 12'd1464;
	localparam logic [11:0] MARGIN_TWO   = 12'd2916;

	typedef enum logic [1:0] {
		REG_CODE_RATE = 2'd0,
		REG_BITS      = 2'd1,
		REG_CARRIERS  = 2'd2,
		REG_NONE      = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RATE_1_2 = 2'd0,
		RATE_2_3 = 2'd1,
		RATE_3_4 = 2'd2,
		RATE_5_6 = 2'd3
	} rate_sel_t;

	typedef struct packed {
		logic [DVD_W-1:0]         dvd;
		logic [DIVA_W-1:0]        rem_a;
		logic [DVD_W-1:0]         quo_a;
		logic [DIVB_W-1:0]        rem_b;
		logic [DVD_W-1:0]         quo_b;
		logic [PAYLOAD_WIDTH-1:0] pay;
	} div_word_t;

	typedef struct packed {
		logic [RATE_W-1:0] code_rate;
		logic [BPS_W-1:0]  bps;
		logic              bps_zero;
	} frame_cfg_t;

	function automatic logic [2:0] rate_num(input logic [RATE_W-1:0] r);
		logic [2:0] v;
		unique case (rate_sel_t'(r))
			RATE_1_2: v = 3'd1;
			RATE_2_3: v = 3'd2;
			RATE_3_4: v = 3'd3;
			RATE_5_6: v = 3'd5;
			default:  v = 3'd1;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] rate_den(input logic [RATE_W-1:0] r);
		logic [2:0] v;
		unique case (rate_sel_t'(r))
			RATE_1_2: v = 3'd2;
			RATE_2_3: v = 3'd3;
			RATE_3_4: v = 3'd4;
			RATE_5_6: v = 3'd6;
			default:  v = 3'd2;
		endcase
		return v;
	endfunction

	// codeword length over the rate denominator, always a whole number
	function automatic logic [SHARE_W-1:0] cw_share(input logic [10:0] cwl,
			input logic [RATE_W-1:0] r);
		logic [SHARE_W-1:0] v;
		logic [1:0]         sel;
		sel = (cwl == CW_SHORT) ? 2'd0 : ((cwl == CW_MID) ? 2'd1 : 2'd2);
		unique case (rate_sel_t'(r))
			RATE_1_2: v = (sel == 2'd0) ? 10'd324 : ((sel == 2'd1) ? 10'd648 : 10'd972);
			RATE_2_3: v = (sel == 2'd0) ? 10'd216 : ((sel == 2'd1) ? 10'd432 : 10'd648);
			RATE_3_4: v = (sel == 2'd0) ? 10'd162 : ((sel == 2'd1) ? 10'd324 : 10'd486);
			RATE_5_6: v = (sel == 2'd0) ? 10'd108 : ((sel == 2'd1) ? 10'd216 : 10'd324);
			default:  v = 10'd0;
		endcase
		return v;
	endfunction

endpackage

### design/ldpcfp_div_cell.sv
// ----------------------------------------------------------------------------
// ldpcfp_div_cell
// one restoring division step for both quotient lanes, registered
// ----------------------------------------------------------------------------
module ldpcfp_div_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_in,
	input  ldpcfp_pkg::div_word_t                  word_in,
	input  logic [ldpcfp_pkg::DIVA_W-1:0]          divisor_a,
	input  logic [ldpcfp_pkg::DIVB_W-1:0]          divisor_b,
	output logic                                   valid_out,
	output ldpcfp_pkg::div_word_t                  word_out
);

	logic                              top_bit;
	logic [ldpcfp_pkg::DIVA_W:0]       trial_a;
	logic [ldpcfp_pkg::DIVB_W:0]       trial_b;
	logic                              ge_a;
	logic                              ge_b;
	logic [ldpcfp_pkg::DIVA_W:0]       diff_a;
	logic [ldpcfp_pkg::DIVB_W:0]       diff_b;
	ldpcfp_pkg::div_word_t             word_next;

	always_comb begin
		top_bit = word_in.dvd[ldpcfp_pkg::DVD_W-1];
		trial_a = {word_in.rem_a, top_bit};
		trial_b = {word_in.rem_b, top_bit};
		ge_a    = trial_a >= {1'b0, divisor_a};
		ge_b    = trial_b >= {1'b0, divisor_b};
		diff_a  = trial_a - {1'b0, divisor_a};
		diff_b  = trial_b - {1'b0, divisor_b};
		word_next       = word_in;
		word_next.dvd   = {word_in.dvd[ldpcfp_pkg::DVD_W-2:0], 1'b0};
		word_next.rem_a = ge_a ? diff_a[ldpcfp_pkg::DIVA_W-1:0]
			: trial_a[ldpcfp_pkg::DIVA_W-1:0];
		word_next.rem_b = ge_b ? diff_b[ldpcfp_pkg::DIVB_W-1:0]
			: trial_b[ldpcfp_pkg::DIVB_W-1:0];
		word_next.quo_a = {word_in.quo_a[ldpcfp_pkg::DVD_W-2:0], ge_a};
		word_next.quo_b = {word_in.quo_b[ldpcfp_pkg::DVD_W-2:0], ge_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		word_out <= word_next;
	end

endmodule

### design/ldpcfp_finish.sv
// ----------------------------------------------------------------------------
// ldpcfp_finish
// turns the quotients into symbol, codeword, shortening and puncture counts
// ----------------------------------------------------------------------------
module ldpcfp_finish (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_in,
	input  ldpcfp_pkg::div_word_t                  word_in,
	input  ldpcfp_pkg::frame_cfg_t                 cfg,
	output logic                                   done,
	output logic [20:0]                            symbol_count,
	output logic [10:0]                            codeword_count,
	output logic [10:0]                            codeword_length,
	output logic [11:0]                            shorten_bits,
	output logic signed [22:0]                     puncture_or_repeat
);

	localparam int SW = ldpcfp_pkg::SYM_W;
	localparam int TW = ldpcfp_pkg::TCB_W;
	localparam int PW = ldpcfp_pkg::PAYLOAD_WIDTH;
	localparam int RW = ldpcfp_pkg::PROD_W;
	localparam int XW = ldpcfp_pkg::EXT_W;
	localparam int LW = TW + 3;

	logic [2:0] k_num;
	logic [2:0] d_den;

	// stage 1
	logic          valid_s1;
	logic [SW-1:0] syms_s1;
	logic [SW-1:0] ncwl_s1;
	logic [PW-1:0] pay_s1;
	// stage 2
	logic          valid_s2;
	logic [SW-1:0] syms_s2;
	logic [SW-1:0] ncwl_s2;
	logic [PW-1:0] pay_s2;
	logic [TW-1:0] tcb_s2;
	// stage 3
	logic          valid_s3;
	logic [SW-1:0] syms_s3;
	logic [SW-1:0] ncw_s3;
	logic [10:0]   cwl_s3;
	logic [PW-1:0] pay_s3;
	logic [TW-1:0] tcb_s3;
	// stage 4
	logic          valid_s4;
	logic [SW-1:0] syms_s4;
	logic [SW-1:0] ncw_s4;
	logic [10:0]   cwl_s4;
	logic [PW-1:0] pay_s4;
	logic [TW-1:0] tcb_s4;
	logic [RW-1:0] prod_s4;

	logic [SW+ldpcfp_pkg::BPS_W-1:0] tcb_full;
	logic [11:0]                     margin;
	logic [LW-1:0]                   lhs;
	logic [LW-1:0]                   rhs;
	logic                            fits;
	logic [SW-1:0]                   ncw_sel;
	logic [10:0]                     cwl_sel;
	logic [XW-1:0]                   alloc;
	logic [XW-1:0]                   spare;
	logic [XW-1:0]                   shrt;
	logic signed [XW-1:0]            pr;
	logic [20:0]                     syms_sat;
	logic [10:0]                     ncw_sat;
	logic [11:0]                     shrt_sat;
	logic signed [22:0]              pr_sat;

	assign k_num = ldpcfp_pkg::rate_num(cfg.code_rate);
	assign d_den = ldpcfp_pkg::rate_den(cfg.code_rate);

	assign tcb_full = syms_s1 * cfg.bps;

	always_comb begin
		if (tcb_s2 <= TW'(ldpcfp_pkg::CW_SHORT)) begin
			margin = ldpcfp_pkg::MARGIN_SHORT;
		end else if (tcb_s2 <= TW'(ldpcfp_pkg::CW_MID)) begin
			margin = ldpcfp_pkg::MARGIN_MID;
		end else begin
			margin = ldpcfp_pkg::MARGIN_TWO;
		end
		lhs  = LW'(d_den) * LW'(tcb_s2);
		rhs  = LW'(d_den) * LW'(pay_s2) + LW'(margin) * LW'(d_den - k_num);
		fits = lhs >= rhs;
		priority if (tcb_s2 <= TW'(ldpcfp_pkg::CW_LONG)) begin
			ncw_sel = SW'(1);
		end else if (tcb_s2 <= TW'(ldpcfp_pkg::TWO_CW_LIMIT)) begin
			ncw_sel = SW'(2);
		end else begin
			ncw_sel = ncwl_s2;
		end
		priority if (tcb_s2 <= TW'(ldpcfp_pkg::CW_SHORT)) begin
			cwl_sel = fits ? ldpcfp_pkg::CW_MID : ldpcfp_pkg::CW_SHORT;
		end else if (tcb_s2 <= TW'(ldpcfp_pkg::CW_MID)) begin
			cwl_sel = fits ? ldpcfp_pkg::CW_LONG : ldpcfp_pkg::CW_MID;
		end else if (tcb_s2 <= TW'(ldpcfp_pkg::CW_LONG)) begin
			cwl_sel = ldpcfp_pkg::CW_LONG;
		end else if (tcb_s2 <= TW'(ldpcfp_pkg::TWO_CW_LIMIT)) begin
			cwl_sel = fits ? ldpcfp_pkg::CW_LONG : ldpcfp_pkg::CW_MID;
		end else begin
			cwl_sel = ldpcfp_pkg::CW_LONG;
		end
	end

	always_comb begin
		alloc = XW'(prod_s4) * XW'(k_num);
		spare = XW'(prod_s4) * XW'(d_den - k_num);
		shrt  = (alloc > XW'(pay_s4)) ? alloc - XW'(pay_s4) : '0;
		pr    = $signed(XW'(pay_s4) + spare - XW'(tcb_s4));
		syms_sat = (syms_s4 > SW'(21'h1FFFFF)) ? 21'h1FFFFF : syms_s4[20:0];
		ncw_sat  = (ncw_s4 > SW'(11'h7FF)) ? 11'h7FF : ncw_s4[10:0];
		shrt_sat = (shrt > XW'(12'hFFF)) ? 12'hFFF : shrt[11:0];
		priority if (pr > $signed(XW'(23'sh3FFFFF))) begin
			pr_sat = 23'sh3FFFFF;
		end else if (pr < $signed(XW'(23'sh400000))) begin
			pr_sat = 23'sh400000;
		end else begin
			pr_sat = pr[22:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done     <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// ceilings from the remainders; no symbols when a symbol carries nothing
		syms_s1 <= cfg.bps_zero ? '0
			: SW'(word_in.quo_a) + SW'(word_in.rem_a != '0);
		ncwl_s1 <= SW'(word_in.quo_b) + SW'(word_in.rem_b != '0);
		pay_s1  <= word_in.pay;

		syms_s2 <= syms_s1;
		ncwl_s2 <= ncwl_s1;
		pay_s2  <= pay_s1;
		tcb_s2  <= tcb_full[TW-1:0];

		syms_s3 <= syms_s2;
		ncw_s3  <= ncw_sel;
		cwl_s3  <= cwl_sel;
		pay_s3  <= pay_s2;
		tcb_s3  <= tcb_s2;

		syms_s4 <= syms_s3;
		ncw_s4  <= ncw_s3;
		cwl_s4  <= cwl_s3;
		pay_s4  <= pay_s3;
		tcb_s4  <= tcb_s3;
		prod_s4 <= RW'(ncw_s3) * RW'(ldpcfp_pkg::cw_share(cwl_s3, cfg.code_rate));

		symbol_count       <= syms_sat;
		codeword_count     <= ncw_sat;
		codeword_length    <= cwl_s4;
		shorten_bits       <= shrt_sat;
		puncture_or_repeat <= pr_sat;
	end

endmodule

### design/ldpc_frame_parameter_calc_unit.sv
// ----------------------------------------------------------------------------
// ldpc_frame_parameter_calc_unit
// ldpc frame parameters from a payload length, one frame per cycle
// ----------------------------------------------------------------------------
// usage:
//   input: payload_bits is taken at a clock edge with start high and busy low.
//   busy stays low, so a new payload can be taken on every cycle.
//   output: done is high for one cycle with the five result fields; the
//   receiver cannot stall, so every result is a transfer in that cycle.
//   path: one input register, one division cell per dividend bit
//   (23 cells for a 20 bit payload) and five finishing stages.
//   throughput: one frame per cycle; the cell chain holds 23 frames at once.
//   configuration: cfg_we writes cfg_wdata into register cfg_idx (code rate,
//   bits per carrier, carrier count); write only while no frame is in flight.
//   reset: arst_n clears all valid flags and loads rate 1/2, one bit per
//   carrier and 52 carriers; frames in flight are dropped.
// ----------------------------------------------------------------------------
`include "ldpc_frame_parameter_calc_unit_defines.svh"

module ldpc_frame_parameter_calc_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [1:0]                              cfg_idx,
	input  logic [ldpcfp_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [ldpcfp_pkg::PAYLOAD_WIDTH-1:0]    payload_bits,
	output logic                                    done,
	output logic [20:0]                             symbol_count,
	output logic [10:0]                             codeword_count,
	output logic [10:0]                             codeword_length,
	output logic [11:0]                             shorten_bits,
	output logic signed [22:0]                      puncture_or_repeat
);

	localparam int NCELL = ldpcfp_pkg::DVD_W;

	logic [ldpcfp_pkg::RATE_W-1:0]  code_rate_q;
	logic [ldpcfp_pkg::BITS_W-1:0]  bits_q;
	logic [ldpcfp_pkg::CARR_W-1:0]  carriers_q;
	logic [ldpcfp_pkg::BPS_W-1:0]   bps_q;
	logic [ldpcfp_pkg::DIVA_W-1:0]  div_a_q;
	logic [ldpcfp_pkg::DIVB_W-1:0]  div_b_q;
	ldpcfp_pkg::frame_cfg_t         fcfg;

	logic                           accept;
	logic                           valid_chain [NCELL+1];
	ldpcfp_pkg::div_word_t          word_chain  [NCELL+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_rate_q <= ldpcfp_pkg::RATE_W'(ldpcfp_pkg::RATE_1_2);
			bits_q      <= ldpcfp_pkg::BITS_W'(1);
			carriers_q  <= ldpcfp_pkg::CARR_W'(52);
		end else if (cfg_we) begin
			unique case (ldpcfp_pkg::cfg_reg_t'(cfg_idx))
				ldpcfp_pkg::REG_CODE_RATE: code_rate_q <= cfg_wdata[ldpcfp_pkg::RATE_W-1:0];
				ldpcfp_pkg::REG_BITS:      bits_q      <= cfg_wdata[ldpcfp_pkg::BITS_W-1:0];
				ldpcfp_pkg::REG_CARRIERS:  carriers_q  <= cfg_wdata[ldpcfp_pkg::CARR_W-1:0];
				default: ;
			endcase
		end
	end

	// divisors are registered from the configuration registers, before any frame reaches a cell
	always_ff @(posedge clk) begin
		bps_q   <= ldpcfp_pkg::BPS_W'(bits_q) * ldpcfp_pkg::BPS_W'(carriers_q);
		div_a_q <= ldpcfp_pkg::DIVA_W'(ldpcfp_pkg::rate_num(code_rate_q))
			* ldpcfp_pkg::DIVA_W'(bits_q) * ldpcfp_pkg::DIVA_W'(carriers_q);
		div_b_q <= ldpcfp_pkg::DIVB_W'(ldpcfp_pkg::rate_num(code_rate_q))
			* ldpcfp_pkg::DIVB_W'(ldpcfp_pkg::CW_LONG);
	end

	assign fcfg.code_rate = code_rate_q;
	assign fcfg.bps       = bps_q;
	assign fcfg.bps_zero  = (bps_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_chain[0] <= 1'b0;
		end else begin
			valid_chain[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		word_chain[0].dvd   <= ldpcfp_pkg::DVD_W'(payload_bits)
			* ldpcfp_pkg::DVD_W'(ldpcfp_pkg::rate_den(code_rate_q));
		word_chain[0].rem_a <= '0;
		word_chain[0].quo_a <= '0;
		word_chain[0].rem_b <= '0;
		word_chain[0].quo_b <= '0;
		word_chain[0].pay   <= payload_bits;
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		ldpcfp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_chain[i]),
			.word_in   (word_chain[i]),
			.divisor_a (div_a_q),
			.divisor_b (div_b_q),
			.valid_out (valid_chain[i+1]),
			.word_out  (word_chain[i+1])
		);
	end

	ldpcfp_finish u_finish (
		.clk                (clk),
		.arst_n             (arst_n),
		.valid_in           (valid_chain[NCELL]),
		.word_in            (word_chain[NCELL]),
		.cfg                (fcfg),
		.done               (done),
		.symbol_count       (symbol_count),
		.codeword_count     (codeword_count),
		.codeword_length    (codeword_length),
		.shorten_bits       (shorten_bits),
		.puncture_or_repeat (puncture_or_repeat)
	);

	`LFP_ASSERT_SAME(a_cwl_legal, done, (codeword_length == ldpcfp_pkg::CW_SHORT) || (codeword_length == ldpcfp_pkg::CW_MID) || (codeword_length == ldpcfp_pkg::CW_LONG), "codeword length not a legal size")
	`LFP_ASSERT_SAME(a_ncw_nonzero, done, codeword_count != '0, "zero codewords reported")
	`LFP_ASSERT_NEXT(a_entry_valid, accept, valid_chain[0], "accepted frame lost at entry")

endmodule
